>>> src/mwmd_pkg.sv
// Package: constants, register codes and sequencer states of the masked window mean downsampler.
`timescale 1ns / 1ps
package mwmd_pkg;

   localparam int MWMD_MAX_COLS = 1024;
   localparam int MWMD_MAX_STEP = 8;

   localparam logic [15:0] ROWS_RESET = 16'd3600;
   localparam logic [10:0] COLS_RESET = 11'd901;
   localparam logic [3:0]  STEP_RESET = 4'd5;

   localparam int SUM_W  = 32;
   localparam int CNT_W  = 9;
   localparam int MEAN_W = 23;

   typedef enum logic [1:0] {
      REG_ROWS = 2'd0,
      REG_COLS = 2'd1,
      REG_STEP = 2'd2,
      REG_NONE = 2'd3
   } reg_index_type;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_RD    = 6'b000100,
      ST_WR    = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

endpackage

>>> src/masked_window_mean_downsampler_unit.sv
// Top level: masked window mean downsampler with banked accumulator memory.
// Sequence: for an input word, up to four accumulators are each read and then written
//   back, and a skipped one is passed over; a word that closes a cell then runs the
//   divider when hits is nonzero and waits in the output state for any output stall.
// Input: a new word is not accepted until the previous one is done and the block is idle.
// Reset: registers take their reset values, then a clearing pass zeroes the accumulator
//   memory; each write to a defined register repeats it.
`timescale 1ns / 1ps
module masked_window_mean_downsampler_unit
   import mwmd_pkg::*;
#(
   parameter int MAX_COLS = MWMD_MAX_COLS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [23:0] req_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_out_row,
   output logic [9:0]  rsp_out_col,
   output logic [22:0] rsp_mean,
   output logic [8:0]  rsp_hits,
   output logic        rsp_frame_end,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int DEPTH = 2 * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int EW    = SUM_W + CNT_W;

   // configuration registers
   logic [15:0] rows_ff;
   logic [10:0] cols_ff;
   logic [3:0]  step_ff;
   logic        cfg_wr;
   reg_index_type cfg_idx;
   logic [15:0] wr_rows;
   logic [10:0] wr_cols;
   logic [3:0]  wr_step;

   // raster position with incremental quotient, remainder and block base
   logic [15:0] r_ff, rrem_ff, qr_ff, rbase_ff;
   logic [10:0] c_ff, crem_ff, qc_ff, cbase_ff;

   // per-word job
   state_type   state_ff, state_in;
   logic [1:0]  k_ff;
   logic [23:0] smp_ff;
   logic        pos_ff, rnext_ff, cnext_ff, emit_ff, fend_ff;
   logic [15:0] jqr_ff;
   logic [10:0] jqc_ff;
   logic [CNT_W-1:0] ecnt_ff;
   logic [AW-1:0] clr_ff;

   // output word
   logic        rsp_valid_ff;
   logic [15:0] orow_ff;
   logic [9:0]  ocol_ff;
   logic [22:0] omean_ff;
   logic [8:0]  ohits_ff;
   logic        ofend_ff;
   logic [MEAN_W-1:0] quo_hold_ff;

   logic accept, load_rsp, rsp_free;
   logic pos_now, emit_now, rnext_now, cnext_now, fend_now;
   logic [16:0] rb_next;
   logic [11:0] cb_next;

   // memory ports
   logic          m_we;
   logic [AW-1:0] m_waddr, m_raddr, job_addr;
   logic [EW-1:0] m_wdata, m_rdata;
   logic          job_en, dr, dc;
   logic [10:0]   job_col;
   logic [SUM_W-1:0] new_sum;
   logic [CNT_W-1:0] new_cnt;

   logic div_start, div_done;
   logic [MEAN_W-1:0] div_q;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite;
   assign cfg_idx    = reg_index_type'(csr_paddr[3:2]);

   // normalize written values: zero reads as one, saturate columns and stride
   always_comb begin
      wr_rows = (csr_pwdata[15:0] == 16'd0) ? 16'd1 : csr_pwdata[15:0];
      wr_cols = (csr_pwdata[10:0] == 11'd0) ? 11'd1 : csr_pwdata[10:0];
      if ({21'd0, wr_cols} > 32'(MAX_COLS)) begin
         wr_cols = 11'(MAX_COLS);
      end
      wr_step = (csr_pwdata[3:0] == 4'd0) ? 4'd1 : csr_pwdata[3:0];
      if ({28'd0, wr_step} > 32'(MWMD_MAX_STEP)) begin
         wr_step = 4'(MWMD_MAX_STEP);
      end
   end

   always_comb begin
      case (cfg_idx)
         REG_ROWS: csr_prdata = {16'd0, rows_ff};
         REG_COLS: csr_prdata = {21'd0, cols_ff};
         REG_STEP: csr_prdata = {28'd0, step_ff};
         default:  csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_RESET;
         cols_ff <= COLS_RESET;
         step_ff <= STEP_RESET;
      end else if (cfg_wr) begin
         case (cfg_idx)
            REG_ROWS: rows_ff <= wr_rows;
            REG_COLS: cols_ff <= wr_cols;
            REG_STEP: step_ff <= wr_step;
            default: ;
         endcase
      end
   end

   // ---------------- input side ----------------
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;

   // positive means sign clear and nonzero
   assign pos_now  = ~req_sample[23] & (req_sample != 24'd0);
   assign rb_next  = {1'b0, rbase_ff} + {13'd0, step_ff};
   assign cb_next  = {1'b0, cbase_ff} + {8'd0, step_ff};
   assign rnext_now = rb_next < {1'b0, rows_ff};
   assign cnext_now = cb_next < {1'b0, cols_ff};
   // a cell closes on the last in-map sample of its stride block
   assign emit_now = ((rrem_ff == {12'd0, step_ff - 4'd1}) || (r_ff == rows_ff - 16'd1)) &&
                     ((crem_ff == {7'd0, step_ff - 4'd1}) || (c_ff == cols_ff - 11'd1));
   assign fend_now = (r_ff == rows_ff - 16'd1) && (c_ff == cols_ff - 11'd1);

   // advance the raster position when a word is taken; restart the frame on a
   // write to a defined register
   always_ff @(posedge clock) begin
      if (reset || (cfg_wr && (cfg_idx != REG_NONE))) begin
         r_ff <= '0; rrem_ff <= '0; qr_ff <= '0; rbase_ff <= '0;
         c_ff <= '0; crem_ff <= '0; qc_ff <= '0; cbase_ff <= '0;
      end else if (accept) begin
         if (c_ff + 11'd1 >= cols_ff) begin
            c_ff <= '0; crem_ff <= '0; qc_ff <= '0; cbase_ff <= '0;
            if (r_ff + 16'd1 >= rows_ff || r_ff == 16'hFFFF) begin
               r_ff <= '0; rrem_ff <= '0; qr_ff <= '0; rbase_ff <= '0;
            end else begin
               r_ff <= r_ff + 16'd1;
               if (rrem_ff == {12'd0, step_ff - 4'd1}) begin
                  rrem_ff  <= '0;
                  qr_ff    <= qr_ff + 16'd1;
                  rbase_ff <= r_ff + 16'd1;
               end else begin
                  rrem_ff <= rrem_ff + 16'd1;
               end
            end
         end else begin
            c_ff <= c_ff + 11'd1;
            if (crem_ff == {7'd0, step_ff - 4'd1}) begin
               crem_ff  <= '0;
               qc_ff    <= qc_ff + 11'd1;
               cbase_ff <= c_ff + 11'd1;
            end else begin
               crem_ff <= crem_ff + 11'd1;
            end
         end
      end
   end

   // capture the job of the accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         smp_ff   <= req_sample;
         pos_ff   <= pos_now;
         rnext_ff <= rnext_now;
         cnext_ff <= cnext_now;
         emit_ff  <= emit_now;
         fend_ff  <= fend_now;
         jqr_ff   <= qr_ff;
         jqc_ff   <= qc_ff;
      end
   end

   // ---------------- accumulator access sequence ----------------
   // order: (row, col+1), (row+1, col), (row+1, col+1), then own cell with emit
   always_comb begin
      case (k_ff)
         2'd0:    begin dr = 1'b0; dc = 1'b1; job_en = pos_ff & cnext_ff; end
         2'd1:    begin dr = 1'b1; dc = 1'b0; job_en = pos_ff & rnext_ff; end
         2'd2:    begin dr = 1'b1; dc = 1'b1; job_en = pos_ff & rnext_ff & cnext_ff; end
         default: begin dr = 1'b0; dc = 1'b0; job_en = 1'b1; end
      endcase
      job_col  = jqc_ff + {10'd0, dc};
      job_addr = (jqr_ff[0] ^ dr) ? AW'(MAX_COLS) + AW'(job_col) : AW'(job_col);
   end

   assign new_sum = m_rdata[EW-1:CNT_W] + (pos_ff ? {8'd0, smp_ff} : 32'd0);
   assign new_cnt = m_rdata[CNT_W-1:0] + {8'd0, pos_ff};

   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;
   assign div_start = (state_ff == ST_WR) && (k_ff == 2'd3) && emit_ff && (new_cnt != '0);
   assign load_rsp  = (state_ff == ST_OUT) && rsp_free;

   always_comb begin
      state_in = state_ff;
      m_we     = 1'b0;
      m_waddr  = job_addr;
      m_wdata  = {new_sum, new_cnt};
      m_raddr  = job_addr;
      case (state_ff)
         ST_CLEAR: begin
            m_we    = 1'b1;
            m_waddr = clr_ff;
            m_wdata = '0;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            if (job_en) begin
               state_in = ST_WR;
            end
         end
         ST_WR: begin
            m_we = 1'b1;
            if (k_ff == 2'd3) begin
               if (emit_ff) begin
                  // emit drains the entry
                  m_wdata  = '0;
                  state_in = (new_cnt != '0) ? ST_DIV : ST_OUT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_RD;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      if (cfg_wr && (cfg_idx != REG_NONE)) begin
         state_in = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (state_in == ST_CLEAR && state_ff != ST_CLEAR) begin
            clr_ff <= '0;
         end else if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (accept) begin
            k_ff <= '0;
         end else if ((state_ff == ST_RD && !job_en) || state_ff == ST_WR) begin
            k_ff <= k_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_WR && k_ff == 2'd3) begin
         ecnt_ff <= new_cnt;
      end
      if (state_ff == ST_WR) begin
         quo_hold_ff <= '0;
      end else if (div_done) begin
         quo_hold_ff <= div_q;
      end
   end

   mwmd_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_acc (
      .clock (clock),
      .we    (m_we),
      .waddr (m_waddr),
      .wdata (m_wdata),
      .raddr (m_raddr),
      .rdata (m_rdata)
   );

   mwmd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (new_sum),
      .divisor  (new_cnt),
      .done     (div_done),
      .quotient (div_q)
   );

   // ---------------- output word ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_rsp) begin
         orow_ff  <= jqr_ff;
         ocol_ff  <= jqc_ff[9:0];
         omean_ff <= quo_hold_ff;
         ohits_ff <= ecnt_ff;
         ofend_ff <= fend_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = orow_ff;
   assign rsp_out_col   = ocol_ff;
   assign rsp_mean      = omean_ff;
   assign rsp_hits      = ohits_ff;
   assign rsp_frame_end = ofend_ff;

   // ---------------- checks ----------------
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall)
      else $error("word accepted during clearing pass");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("pending result overwritten");

   a_div_in_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide state");

   a_div_leads_out: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (state_ff == ST_DIV))
      else $error("divide started without entering divide state");

endmodule

>>> src/mwmd_ram.sv
// Generic synchronous RAM: one write port, one registered read port.
`timescale 1ns / 1ps
module mwmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

>>> src/mwmd_div.sv
// Restoring divider: 32-bit sum by 9-bit count, one quotient bit per cycle.
`timescale 1ns / 1ps
module mwmd_div
   import mwmd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  dividend,
   input  logic [CNT_W-1:0]  divisor,
   output logic              done,
   output logic [MEAN_W-1:0] quotient
);
   logic              busy_ff, busy_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [MEAN_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W:0]    trial;
   logic              fits;

   // quotient is known to fit in 23 bits, so the top 9 bits seed the remainder
   assign trial = {rem_ff, quo_ff[MEAN_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      done    = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd0;
         rem_in  = dividend[SUM_W-1:MEAN_W];
         quo_in  = dividend[MEAN_W-1:0];
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? CNT_W'(trial - {1'b0, dsr_ff}) : trial[CNT_W-1:0];
         quo_in = {quo_ff[MEAN_W-2:0], fits};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(MEAN_W - 1)) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end
      end
   end

   assign quotient = quo_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end
endmodule

>>> bench/mwmd_checker.sv
// Checker: predicts downsampled cells from accepted words and compares result words.
`timescale 1ns / 1ps
module mwmd_checker
   import mwmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [23:0] req_sample,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_out_row,
   input  logic [9:0]  rsp_out_col,
   input  logic [22:0] rsp_mean,
   input  logic [8:0]  rsp_hits,
   input  logic        rsp_frame_end,
   input  logic        cfg_write,
   input  logic [1:0]  cfg_index,
   input  logic [31:0] cfg_value,
   output int          fail_count,
   output int          pending_cells
);
   typedef struct packed {
      logic [15:0] out_row;
      logic [9:0]  out_col;
      logic [22:0] mean;
      logic [8:0]  hits;
      logic        frame_end;
   } cell_word_type;

   cell_word_type cell_queue[$];
   logic [31:0] acc_sum[2*MWMD_MAX_COLS];
   logic [8:0]  acc_cnt[2*MWMD_MAX_COLS];
   int unsigned map_rows, map_cols, stride, row_at, col_at;

   assign pending_cells = cell_queue.size();

   function automatic void clear_map();
      for (int i = 0; i < 2*MWMD_MAX_COLS; i++) begin
         acc_sum[i] = '0;
         acc_cnt[i] = '0;
      end
      row_at = 0;
      col_at = 0;
   endfunction

   function automatic void take_register(logic [1:0] index, logic [31:0] value);
      int unsigned v;
      if (index == REG_ROWS) begin
         v = value[15:0];
         map_rows = (v == 0) ? 1 : v;
      end else if (index == REG_COLS) begin
         v = value[10:0];
         if (v == 0) v = 1;
         if (v > MWMD_MAX_COLS) v = MWMD_MAX_COLS;
         map_cols = v;
      end else if (index == REG_STEP) begin
         v = value[3:0];
         if (v == 0) v = 1;
         if (v > MWMD_MAX_STEP) v = MWMD_MAX_STEP;
         stride = v;
      end else begin
         return;
      end
      clear_map();
   endfunction

   // Accumulate one sample and queue the cell it completes, if any.
   function automatic void accumulate_sample(logic [23:0] raw);
      int unsigned n_r, n_c, qr, qc, lr, lc, ix, cr, cc;
      cell_word_type exp_word;
      n_r = (map_rows + stride - 1) / stride;
      n_c = (map_cols + stride - 1) / stride;
      qr = row_at / stride;
      qc = col_at / stride;
      if (!raw[23] && raw != 0) begin
         for (int dr = 0; dr < 2; dr++)
            for (int dc = 0; dc < 2; dc++) begin
               cr = qr + dr;
               cc = qc + dc;
               if (cr < n_r && cc < n_c && cc < MWMD_MAX_COLS) begin
                  ix = (cr % 2) * MWMD_MAX_COLS + cc;
                  acc_sum[ix] += {8'd0, raw};
                  acc_cnt[ix] += 1;
               end
            end
      end
      lr = stride * qr + stride - 1;
      if (lr > map_rows - 1) lr = map_rows - 1;
      lc = stride * qc + stride - 1;
      if (lc > map_cols - 1) lc = map_cols - 1;
      if (row_at == lr && col_at == lc && qc < MWMD_MAX_COLS) begin
         ix = (qr % 2) * MWMD_MAX_COLS + qc;
         exp_word.out_row   = qr[15:0];
         exp_word.out_col   = qc[9:0];
         exp_word.hits      = acc_cnt[ix];
         exp_word.mean      = (acc_cnt[ix] != 0) ? 23'(acc_sum[ix] / acc_cnt[ix]) : '0;
         exp_word.frame_end = (row_at == map_rows - 1 && col_at == map_cols - 1);
         cell_queue.push_back(exp_word);
         acc_sum[ix] = '0;
         acc_cnt[ix] = '0;
      end
      col_at++;
      if (col_at >= map_cols) begin
         col_at = 0;
         row_at++;
         if (row_at >= map_rows) row_at = 0;
      end
   endfunction

   always @(posedge clock) begin
      cell_word_type want;
      int errs;
      errs = 0;
      if (reset) begin
         map_rows = ROWS_RESET;
         map_cols = COLS_RESET;
         stride = STEP_RESET;
         clear_map();
         cell_queue.delete();
         fail_count <= 0;
      end else begin
         if (cfg_write) take_register(cfg_index, cfg_value);
         if (rsp_valid && !rsp_stall) begin
            if (cell_queue.size() == 0) begin
               $error("unexpected result word row %0d col %0d", rsp_out_row, rsp_out_col);
               errs++;
            end else begin
               want = cell_queue.pop_front();
               if (want.out_row !== rsp_out_row) begin
                  $error("out_row expected %0d actual %0d", want.out_row, rsp_out_row);
                  errs++;
               end
               if (want.out_col !== rsp_out_col) begin
                  $error("out_col expected %0d actual %0d", want.out_col, rsp_out_col);
                  errs++;
               end
               if (want.mean !== rsp_mean) begin
                  $error("mean expected %0d actual %0d", want.mean, rsp_mean);
                  errs++;
               end
               if (want.hits !== rsp_hits) begin
                  $error("hits expected %0d actual %0d", want.hits, rsp_hits);
                  errs++;
               end
               if (want.frame_end !== rsp_frame_end) begin
                  $error("frame_end expected %0d actual %0d", want.frame_end, rsp_frame_end);
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall) accumulate_sample(req_sample);
         fail_count <= fail_count + errs;
      end
   end
endmodule

>>> bench/tb_masked_window_mean_downsampler_unit.sv
// Testbench top: drives samples and register writes, then reports the verdict.
`timescale 1ns / 1ps
module tb_masked_window_mean_downsampler_unit
   import mwmd_pkg::*;
;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [23:0] req_sample = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_out_row;
   logic [9:0]  rsp_out_col;
   logic [22:0] rsp_mean;
   logic [8:0]  rsp_hits;
   logic        rsp_frame_end;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending_cells;
   logic        rsp_long_idle = 1'b0;

   // Toggle the clock every half period.
   always #4 clock = ~clock;

   masked_window_mean_downsampler_unit u_dut (.*);

   // A register lands at the edge where the access phase is accepted.
   mwmd_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_sample,
      .rsp_valid, .rsp_stall, .rsp_out_row, .rsp_out_col, .rsp_mean,
      .rsp_hits, .rsp_frame_end,
      .cfg_write(csr_psel && csr_penable && csr_pwrite && csr_pready),
      .cfg_index(csr_paddr[3:2]), .cfg_value(csr_pwdata),
      .fail_count, .pending_cells
   );

   // Stall the result side at random: mostly short stalls, a few long ones,
   // and quiet stretches with no stall at all.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 199) == 0) begin
         rsp_long_idle <= ~rsp_long_idle;
      end else if (rsp_long_idle) begin
         rsp_stall <= 1'b0;
      end else begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3: rsp_stall <= 1'b1;
            4:          rsp_stall <= ($urandom_range(0, 3) != 0);
            default:    rsp_stall <= 1'b0;
         endcase
      end
   end

   // Write one register through a setup phase and an access phase.
   task automatic write_register(input reg_index_type index, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Hold a sample word until it is accepted, after a random gap; valid stays
   // high into the next word when there is no gap.
   task automatic send_sample(input logic [23:0] value);
      int gap;
      case ($urandom_range(0, 9))
         0, 1, 2: gap = $urandom_range(1, 3);
         3:       gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : 0;
         default: gap = 0;
      endcase
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Drop valid, drain expected cells, then let the block finish its clearing pass.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_cells != 0) @(posedge clock);
      repeat (2 * MWMD_MAX_COLS + 64) @(posedge clock);
   endtask

   function automatic logic [23:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return 24'h000000;
         1:       return 24'h7FFFFF;
         2:       return 24'h800000;
         3:       return 24'h000001;
         4, 5:    return 24'($urandom) | 24'h800000;
         default: return {1'b0, 23'($urandom)};
      endcase
   endfunction

   task automatic configure(input int rows, input int cols, input int stride);
      wait_idle();
      write_register(REG_ROWS, rows);
      write_register(REG_COLS, cols);
      write_register(REG_STEP, stride);
      write_register(REG_NONE, $urandom);
      repeat (2 * MWMD_MAX_COLS + 64) @(posedge clock);
   endtask

   initial begin
      int rows, cols, stride;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (2 * MWMD_MAX_COLS + 64) @(posedge clock);

      // Directed: 3x4 map, step 2, extremes and signs at the edges.
      configure(3, 4, 2);
      send_sample(24'h7FFFFF);
      send_sample(24'h800000);
      send_sample(24'h000001);
      send_sample(24'h000000);
      send_sample(24'hFFFFFF);
      send_sample(24'h7FFFFF);
      send_sample(24'h7FFFFF);
      send_sample(24'h123456);
      send_sample(24'h000002);
      send_sample(24'h400000);
      send_sample(24'h7FFFFF);
      send_sample(24'h800001);
      // Frame wrap: part of a second frame.
      send_sample(24'h000010);
      send_sample(24'h000020);

      // Degenerate registers: zero sizes and zero step become one.
      configure(0, 0, 0);
      send_sample(24'h000005);
      send_sample(24'h800000);
      send_sample(24'h7FFFFF);
      // Oversized columns and step saturate.
      configure(1, 2047, 15);
      for (int i = 0; i < 8; i++) send_sample(random_sample());

      // Random phases: mostly small maps, 64 samples per phase.
      for (int ph = 0; ph < 24; ph++) begin
         rows = $urandom_range(1, 12);
         cols = $urandom_range(1, 12);
         stride = $urandom_range(0, 15);
         if (ph == 5) begin rows = 65535; cols = 1024; stride = 8; end
         if (ph == 6) begin rows = 2; cols = 1024; stride = 1; end
         configure(rows, cols, stride);
         for (int i = 0; i < 64; i++) send_sample(random_sample());
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Bound the run well past the slowest correct one.
   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end
endmodule
